// File: rtl/smrs_pkg.sv
// Shared constants and types for the sorted multiset rank/select block.
package smrs_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_W        = 32;
	localparam int RANK_W       = 11;
	localparam int COUNT_OUT_W  = 11;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_SEL
	} state_t;

endpackage

// File: rtl/sorted_multiset_rank_select.sv
// Top level of the sorted multiset: insert keys, select the k-th smallest.
//
// Keys sit in ascending order in one RAM (one write and one registered read per cycle).
// A request is taken when start is high and busy is low, and every request gives one
// result, shown for one cycle with done high. A select with a good rank holds busy while
// it reads the RAM in ST_SEL and shows its result in the cycle after. An insert holds busy
// while the shift loop moves each stored key greater than the new key up, one entry per
// cycle: read the entry below, write it one place up, then the new key. An insert into an
// empty store, an insert into a full store and a select with a bad rank show their result
// in the cycle right after the request and raise no busy. Results cannot be held off. After
// reset the RAM needs no clearing: only entries below the count are ever read.
module sorted_multiset_rank_select #(
	parameter int CAPACITY = smrs_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             operation,
	input  logic signed [smrs_pkg::KEY_W-1:0] key_value,
	input  logic [smrs_pkg::RANK_W-1:0]      rank,
	output logic                             done,
	output logic [1:0]                       status,
	output logic signed [smrs_pkg::KEY_W-1:0] selected_key,
	output logic [smrs_pkg::COUNT_OUT_W-1:0] stored_count
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > smrs_pkg::RANK_W) ? CW : smrs_pkg::RANK_W;
	localparam int OW   = (CMPW > smrs_pkg::COUNT_OUT_W) ? CMPW : smrs_pkg::COUNT_OUT_W;

	smrs_pkg::state_t  state_q, state_d;
	smrs_pkg::status_t status_q, status_d;
	logic [AW-1:0]     pos_q, pos_d;
	logic [CW-1:0]     count_q, count_d;
	logic signed [smrs_pkg::KEY_W-1:0] key_q, key_d;
	logic signed [smrs_pkg::KEY_W-1:0] sel_q, sel_d;
	logic              done_q, done_d;

	logic                       we, re;
	logic [AW-1:0]              waddr, raddr;
	logic [smrs_pkg::KEY_W-1:0] wdata, rdata;
	logic [CMPW-1:0]            rank_ext, count_ext;

	assign rank_ext  = CMPW'(rank);
	assign count_ext = CMPW'(count_q);

	smrs_ram #(
		.WIDTH(smrs_pkg::KEY_W),
		.DEPTH(CAPACITY)
	) u_keys (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Next state, RAM access and result
	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		count_d  = count_q;
		key_d    = key_q;
		we       = 1'b0;
		waddr    = pos_q;
		wdata    = key_q;
		re       = 1'b0;
		raddr    = pos_q - AW'(1);
		done_d   = 1'b0;
		status_d = smrs_pkg::STATUS_OK;
		sel_d    = '0;
		unique case (state_q)
			smrs_pkg::ST_IDLE: begin
				if (start) begin
					key_d = key_value;
					if (operation == smrs_pkg::OP_INSERT) begin
						if (count_q == CW'(CAPACITY)) begin
							done_d   = 1'b1;
							status_d = smrs_pkg::STATUS_FULL;
						end else if (count_q == '0) begin
							we      = 1'b1;
							waddr   = '0;
							wdata   = key_value;
							count_d = count_q + CW'(1);
							done_d  = 1'b1;
						end else begin
							re      = 1'b1;
							raddr   = AW'(count_q - CW'(1));
							pos_d   = AW'(count_q);
							state_d = smrs_pkg::ST_SHIFT;
						end
					end else begin
						if (rank_ext == '0 || rank_ext > count_ext) begin
							done_d   = 1'b1;
							status_d = smrs_pkg::STATUS_RANGE;
						end else begin
							re      = 1'b1;
							raddr   = AW'(rank_ext - CMPW'(1));
							state_d = smrs_pkg::ST_SEL;
						end
					end
				end
			end
			smrs_pkg::ST_SHIFT: begin
				// Move the larger key up one place, or drop the new key in
				if (key_q < $signed(rdata)) begin
					we    = 1'b1;
					waddr = pos_q;
					wdata = rdata;
					pos_d = pos_q - AW'(1);
					if (pos_q == AW'(1)) begin
						state_d = smrs_pkg::ST_PLACE;
					end else begin
						re    = 1'b1;
						raddr = pos_q - AW'(2);
					end
				end else begin
					we      = 1'b1;
					waddr   = pos_q;
					wdata   = key_q;
					count_d = count_q + CW'(1);
					done_d  = 1'b1;
					state_d = smrs_pkg::ST_IDLE;
				end
			end
			smrs_pkg::ST_PLACE: begin
				we      = 1'b1;
				waddr   = '0;
				wdata   = key_q;
				count_d = count_q + CW'(1);
				done_d  = 1'b1;
				state_d = smrs_pkg::ST_IDLE;
			end
			smrs_pkg::ST_SEL: begin
				done_d  = 1'b1;
				sel_d   = rdata;
				state_d = smrs_pkg::ST_IDLE;
			end
			default: begin
				state_d = smrs_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smrs_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		key_q    <= key_d;
		sel_q    <= sel_d;
		status_q <= status_d;
	end

	// Drive result ports
	logic [OW-1:0] count_wide;
	assign count_wide   = OW'(count_q);
	assign busy         = (state_q != smrs_pkg::ST_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign selected_key = sel_q;
	assign stored_count = count_wide[smrs_pkg::COUNT_OUT_W-1:0];

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("key count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> count_q == CW'($past(count_q) + CW'(1)))
		else $error("key count moved by other than one");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != 2'(smrs_pkg::STATUS_OK)) |-> selected_key == '0)
		else $error("failed request carries a key");

	a_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smrs_pkg::ST_SHIFT) |-> pos_q != '0)
		else $error("shift loop ran past the bottom entry");
`endif

endmodule

// File: rtl/smrs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module smrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/sv/sorted_multiset_rank_select_tb.sv
// Testbench for the sorted multiset: inserts and rank selects checked against a shadow copy.
`timescale 1ns / 1ps

module sorted_multiset_rank_select_tb;

	localparam int CAPACITY       = smrs_pkg::CAPACITY_DEF;
	localparam int KEY_W          = smrs_pkg::KEY_W;
	localparam int RANK_W         = smrs_pkg::RANK_W;
	localparam int COUNT_OUT_W    = smrs_pkg::COUNT_OUT_W;
	localparam int CLK_HALF       = 2;
	localparam int RESET_CYCLES   = 11;
	localparam int SETTLE_CYCLES  = 20;
	localparam int IDLE_LIMIT     = 20 * CAPACITY;

	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct {
		smrs_pkg::status_t        status;
		logic signed [KEY_W-1:0]  key;
		logic [COUNT_OUT_W-1:0]   count;
	} rank_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     operation;
	logic signed [KEY_W-1:0]  key_value;
	logic [RANK_W-1:0]        rank;
	logic                     done;
	logic [1:0]               status;
	logic signed [KEY_W-1:0]  selected_key;
	logic [COUNT_OUT_W-1:0]   stored_count;

	// shadow copy of the store, ascending signed order
	logic signed [KEY_W-1:0]  shadow_keys [CAPACITY];
	int                       shadow_count;

	rank_result_t             awaited_results [$];
	rank_result_t             got_expected;
	int                       error_count;
	int                       burst_left;
	int                       idle_cycles;

	sorted_multiset_rank_select #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.key_value    (key_value),
		.rank         (rank),
		.done         (done),
		.status       (status),
		.selected_key (selected_key),
		.stored_count (stored_count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Apply one request to the shadow store and return the result it should give.
	function automatic rank_result_t compute_rank_result(logic op,
		logic signed [KEY_W-1:0] key, logic [RANK_W-1:0] k);
		rank_result_t res;
		int pos;
		res.status = smrs_pkg::STATUS_OK;
		res.key    = '0;
		if (op == smrs_pkg::OP_INSERT) begin
			if (shadow_count >= CAPACITY) begin
				res.status = smrs_pkg::STATUS_FULL;
			end else begin
				// shift larger keys up; equal keys stay below the new one
				pos = shadow_count;
				while (pos > 0 && key < shadow_keys[pos-1]) begin
					shadow_keys[pos] = shadow_keys[pos-1];
					pos--;
				end
				shadow_keys[pos] = key;
				shadow_count++;
			end
		end else begin
			if (k == 0 || int'(k) > shadow_count)
				res.status = smrs_pkg::STATUS_RANGE;
			else
				res.key = shadow_keys[k-1];
		end
		res.count = shadow_count[COUNT_OUT_W-1:0];
		return res;
	endfunction

	// Draw a key: mostly uniform, some duplicates of stored keys, some extremes, some small keys near zero.
	function automatic logic signed [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 2 && shadow_count > 0)
			return shadow_keys[$urandom_range(0, shadow_count - 1)];
		else if (sel == 2)
			return KEY_MIN;
		else if (sel == 3)
			return KEY_MAX;
		else if (sel == 4)
			return $signed(32'($urandom_range(0, 15))) - 8;
		return $signed($urandom);
	endfunction

	// Pick a select rank: mostly in range, sometimes zero or past the count.
	function automatic logic [RANK_W-1:0] pick_rank();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7 && shadow_count > 0)
			return RANK_W'($urandom_range(1, shadow_count));
		else if (sel == 7)
			return '0;
		else if (sel == 8 && shadow_count < CAPACITY)
			return RANK_W'(shadow_count + 1);
		return RANK_W'($urandom_range(0, CAPACITY));
	endfunction

	// Send one request; often idle between bursts, then hold start until busy is low.
	task automatic send_request(logic op, logic signed [KEY_W-1:0] key,
		logic [RANK_W-1:0] k);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		operation <= op;
		key_value <= key;
		rank      <= k;
		start     <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		awaited_results.push_back(compute_rank_result(op, key, k));
		@(negedge clk);
	endtask

	// Drop start and hold until every awaited result is back.
	task automatic drain_results();
		start <= 1'b0;
		burst_left = 0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic test_empty_store();
		send_request(smrs_pkg::OP_SELECT, 32'sd0, '0);
		send_request(smrs_pkg::OP_SELECT, $signed($urandom), 11'd1);
		send_request(smrs_pkg::OP_SELECT, $signed($urandom), RANK_W'(CAPACITY));
	endtask

	task automatic test_insert_extremes();
		send_request(smrs_pkg::OP_INSERT, 32'sd0, RANK_W'($urandom_range(0, CAPACITY)));
		send_request(smrs_pkg::OP_INSERT, KEY_MIN, '0);
		send_request(smrs_pkg::OP_INSERT, KEY_MAX, RANK_W'(CAPACITY));
		send_request(smrs_pkg::OP_INSERT, -32'sd1, 11'd1);
		send_request(smrs_pkg::OP_INSERT, 32'sd1, '0);
		// duplicates of stored keys
		send_request(smrs_pkg::OP_INSERT, 32'sd0, '0);
		send_request(smrs_pkg::OP_INSERT, KEY_MAX, '0);
		send_request(smrs_pkg::OP_INSERT, KEY_MIN, RANK_W'(CAPACITY));
	endtask

	task automatic test_select_edges();
		send_request(smrs_pkg::OP_SELECT, KEY_MAX, '0);
		send_request(smrs_pkg::OP_SELECT, KEY_MIN, 11'd1);
		send_request(smrs_pkg::OP_SELECT, $signed($urandom), RANK_W'(shadow_count));
		send_request(smrs_pkg::OP_SELECT, $signed($urandom), RANK_W'(shadow_count + 1));
		send_request(smrs_pkg::OP_SELECT, -32'sd1, RANK_W'(CAPACITY));
		send_request(smrs_pkg::OP_SELECT, $signed($urandom), 11'd4);
		send_request(smrs_pkg::OP_SELECT, $signed($urandom), 11'd5);
		drain_results();
	endtask

	task automatic test_random_growth();
		repeat (350) begin
			if ($urandom_range(0, 9) < 7)
				send_request(smrs_pkg::OP_INSERT, pick_key(),
					RANK_W'($urandom_range(0, CAPACITY)));
			else
				send_request(smrs_pkg::OP_SELECT, $signed($urandom), pick_rank());
		end
	endtask

	task automatic test_fill_to_capacity();
		while (shadow_count < CAPACITY) begin
			if ($urandom_range(0, 19) == 0)
				send_request(smrs_pkg::OP_SELECT, $signed($urandom), pick_rank());
			else if ($urandom_range(0, 19) < 17)
				// a maximum key lands on top, so the insert shifts nothing
				send_request(smrs_pkg::OP_INSERT, KEY_MAX,
					RANK_W'($urandom_range(0, CAPACITY)));
			else
				send_request(smrs_pkg::OP_INSERT, pick_key(),
					RANK_W'($urandom_range(0, CAPACITY)));
		end
		drain_results();
	endtask

	task automatic test_full_store();
		send_request(smrs_pkg::OP_INSERT, KEY_MIN, '0);
		send_request(smrs_pkg::OP_SELECT, $signed($urandom), RANK_W'(CAPACITY));
		send_request(smrs_pkg::OP_SELECT, $signed($urandom), 11'd1);
		send_request(smrs_pkg::OP_SELECT, $signed($urandom), '0);
		repeat (150) begin
			if ($urandom_range(0, 1) == 0)
				send_request(smrs_pkg::OP_INSERT, pick_key(),
					RANK_W'($urandom_range(0, CAPACITY)));
			else
				send_request(smrs_pkg::OP_SELECT, $signed($urandom), pick_rank());
		end
	endtask

	// Compare each result with the oldest awaited one.
	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$error("result with none awaited: status=%0d selected_key=%0d stored_count=%0d",
					status, selected_key, stored_count);
				error_count++;
			end else begin
				got_expected = awaited_results.pop_front();
				if (status !== got_expected.status) begin
					$error("status: expected %0d, actual %0d", got_expected.status, status);
					error_count++;
				end
				if (selected_key !== got_expected.key) begin
					$error("selected_key: expected %0d, actual %0d",
						got_expected.key, selected_key);
					error_count++;
				end
				if (stored_count !== got_expected.count) begin
					$error("stored_count: expected %0d, actual %0d",
						got_expected.count, stored_count);
					error_count++;
				end
			end
		end
	end

	// Stop the run when neither a request nor a result moves for too long.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sorted_multiset_rank_select test failed");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		operation    = smrs_pkg::OP_INSERT;
		key_value    = '0;
		rank         = '0;
		shadow_count = 0;
		error_count  = 0;
		burst_left   = 0;
		idle_cycles  = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_store();
		test_insert_extremes();
		test_select_edges();
		test_random_growth();
		test_fill_to_capacity();
		test_full_store();
		drain_results();

		if (error_count == 0)
			$display("sorted_multiset_rank_select test passed");
		else
			$display("sorted_multiset_rank_select test failed");
		$finish;
	end

endmodule

// File: files.f
rtl/smrs_pkg.sv
rtl/smrs_ram.sv
rtl/sorted_multiset_rank_select.sv
tb/sv/sorted_multiset_rank_select_tb.sv
